/* rtl/pcrt_pkg.sv */
package pcrt_pkg;

  // Coordinate format: signed Q15.8 at the default width
  localparam int CW       = 24;
  localparam int ROT_W    = 16;              // one Q1.14 rotation entry
  localparam int ROW_W    = 3 * ROT_W;       // one packed rotation row
  localparam int FRAC_W   = 14;              // fraction bits of a rotation entry
  localparam int DIFF_W   = CW + 1;          // p - c
  localparam int PROD_W   = DIFF_W + ROT_W;  // entry * (p - c)
  localparam int ACC_W    = PROD_W + 2;      // sum of three products plus bias
  localparam int RND_W    = ACC_W - FRAC_W;  // row after round and shift
  localparam int SUM_W    = RND_W + 2;       // row + shift + center
  localparam int ROUND_BIAS = 1 << (FRAC_W - 1);
  localparam int IDX_W    = 3;

  typedef logic signed [CW-1:0]     coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic [ROW_W-1:0]         row_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } coord_vec_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } diff_vec_t;

  typedef enum logic {
    MODE_BOX   = 1'b0,
    MODE_XFORM = 1'b1
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_SHIFT_X  = 3'd3,
    REG_SHIFT_Y  = 3'd4,
    REG_SHIFT_Z  = 3'd5
  } cfg_reg_t;

  localparam row_t ROW0_RST = row_t'(1 << FRAC_W) << (2 * ROT_W);
  localparam row_t ROW1_RST = row_t'(1 << FRAC_W) << ROT_W;
  localparam row_t ROW2_RST = row_t'(1 << FRAC_W);

endpackage

/* rtl/pcrt_row.sv */
module pcrt_row (
  input  logic               clk,
  input  logic               en,
  input  pcrt_pkg::row_t     rot_row,
  input  pcrt_pkg::diff_vec_t d,
  input  pcrt_pkg::coord_t   cen,
  input  pcrt_pkg::coord_t   shift,
  output pcrt_pkg::coord_t   q,
  output logic               clip
);
  import pcrt_pkg::*;

  rot_t  e0, e1, e2;
  prod_t prod0_r, prod1_r, prod2_r;
  prod_t prod0_nxt, prod1_nxt, prod2_nxt;
  coord_t cen3_r, cen4_r;
  acc_t  acc_sum;
  rnd_t  rnd_r, rnd_nxt;
  sum_t  tot;

  assign e0 = rot_t'(rot_row[3*ROT_W-1:2*ROT_W]);
  assign e1 = rot_t'(rot_row[2*ROT_W-1:ROT_W]);
  assign e2 = rot_t'(rot_row[ROT_W-1:0]);

  assign prod0_nxt = prod_t'(e0) * prod_t'(d.x);
  assign prod1_nxt = prod_t'(e1) * prod_t'(d.y);
  assign prod2_nxt = prod_t'(e2) * prod_t'(d.z);

  // Round half up, then floor-shift back to Q15.8
  assign acc_sum = acc_t'(prod0_r) + acc_t'(prod1_r) + acc_t'(prod2_r)
                 + acc_t'(ROUND_BIAS);
  assign rnd_nxt = rnd_t'(acc_sum >>> FRAC_W);

  assign tot = sum_t'(rnd_r) + sum_t'(shift) + sum_t'(cen4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      prod0_r <= prod0_nxt;
      prod1_r <= prod1_nxt;
      prod2_r <= prod2_nxt;
      cen3_r  <= cen;
      rnd_r   <= rnd_nxt;
      cen4_r  <= cen3_r;
    end
  end

  always_comb begin
    if (tot > sum_t'(COORD_MAX)) begin
      q    = COORD_MAX;
      clip = 1'b1;
    end else if (tot < sum_t'(COORD_MIN)) begin
      q    = COORD_MIN;
      clip = 1'b1;
    end else begin
      q    = coord_t'(tot);
      clip = 1'b0;
    end
  end

endmodule

/* rtl/point_cloud_rigid_transform_about_center.sv */
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_mode, in_px, in_py, in_pz
// out_      output     out_valid / out_ready  out_qx, out_qy, out_qz, out_clipped
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat per cycle in and out while the pipe advances. A transform beat passes
// through the input register, center/difference stage, product stage, round stage
// and result register before it shows on out_valid. A box beat gives no result.
// The whole pipe advances unless the result register holds an unclaimed beat;
// then in_ready drops until out_ready takes it. Config is always ready.
// Reset (rst_n low, synchronous) empties the pipe, restores the identity
// rotation and zero shift, and marks the box empty and due for restart.
module point_cloud_rigid_transform_about_center (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  pcrt_pkg::coord_t   in_px,
  input  pcrt_pkg::coord_t   in_py,
  input  pcrt_pkg::coord_t   in_pz,
  output logic               out_valid,
  input  logic               out_ready,
  output pcrt_pkg::coord_t   out_qx,
  output pcrt_pkg::coord_t   out_qy,
  output pcrt_pkg::coord_t   out_qz,
  output logic               out_clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [pcrt_pkg::IDX_W-1:0] cfg_index,
  input  pcrt_pkg::row_t     cfg_data
);
  import pcrt_pkg::*;

  // Pipe advance: result register empty or being drained
  logic adv;

  // Config registers
  row_t   rot_row0_r, rot_row1_r, rot_row2_r;
  coord_t shift_x_r, shift_y_r, shift_z_r;

  // Stage 1: input register
  logic       v1_r;
  mode_t      mode1_r;
  coord_vec_t p1_r;

  // Bounding box
  coord_vec_t min_r, max_r, min_nxt, max_nxt;
  logic       box_valid_r, restart_r;
  coord_vec_t cen;
  diff_t      csum_x, csum_y, csum_z;

  // Stage 2: difference and center
  logic       v2_r;
  diff_vec_t  d2_r, d2_nxt;
  coord_vec_t c2_r;

  // Stages 3 and 4 live in the row units; track valid here
  logic v3_r, v4_r;

  coord_t qx, qy, qz;
  logic   clip_x, clip_y, clip_z;

  // Result register
  logic   out_valid_r;
  coord_t qx_r, qy_r, qz_r;
  logic   clip_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row0_r <= ROW0_RST;
      rot_row1_r <= ROW1_RST;
      rot_row2_r <= ROW2_RST;
      shift_x_r  <= '0;
      shift_y_r  <= '0;
      shift_z_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROT_ROW0: rot_row0_r <= cfg_data;
        REG_ROT_ROW1: rot_row1_r <= cfg_data;
        REG_ROT_ROW2: rot_row2_r <= cfg_data;
        REG_SHIFT_X:  shift_x_r  <= coord_t'(cfg_data[CW-1:0]);
        REG_SHIFT_Y:  shift_y_r  <= coord_t'(cfg_data[CW-1:0]);
        REG_SHIFT_Z:  shift_z_r  <= coord_t'(cfg_data[CW-1:0]);
        default: ;
      endcase
    end
  end

  // Capture the incoming beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r <= mode_t'(in_mode);
      p1_r    <= '{x: in_px, y: in_py, z: in_pz};
    end
  end

  // Box widening; a restart replaces the box with this point
  always_comb begin
    if (restart_r) begin
      min_nxt = p1_r;
      max_nxt = p1_r;
    end else begin
      min_nxt.x = (p1_r.x < min_r.x) ? p1_r.x : min_r.x;
      min_nxt.y = (p1_r.y < min_r.y) ? p1_r.y : min_r.y;
      min_nxt.z = (p1_r.z < min_r.z) ? p1_r.z : min_r.z;
      max_nxt.x = (p1_r.x > max_r.x) ? p1_r.x : max_r.x;
      max_nxt.y = (p1_r.y > max_r.y) ? p1_r.y : max_r.y;
      max_nxt.z = (p1_r.z > max_r.z) ? p1_r.z : max_r.z;
    end
  end

  // Center = floor((max + min) / 2), zero while the box is empty
  assign csum_x = diff_t'(max_r.x) + diff_t'(min_r.x);
  assign csum_y = diff_t'(max_r.y) + diff_t'(min_r.y);
  assign csum_z = diff_t'(max_r.z) + diff_t'(min_r.z);

  always_comb begin
    if (box_valid_r) begin
      cen.x = coord_t'(csum_x >>> 1);
      cen.y = coord_t'(csum_y >>> 1);
      cen.z = coord_t'(csum_z >>> 1);
    end else begin
      cen = '0;
    end
    d2_nxt.x = diff_t'(p1_r.x) - diff_t'(cen.x);
    d2_nxt.y = diff_t'(p1_r.y) - diff_t'(cen.y);
    d2_nxt.z = diff_t'(p1_r.z) - diff_t'(cen.z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_valid_r <= 1'b0;
      restart_r   <= 1'b1;
      v2_r        <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r && (mode1_r == MODE_XFORM);
      if (v1_r) begin
        case (mode1_r)
          MODE_BOX: begin
            box_valid_r <= 1'b1;
            restart_r   <= 1'b0;
          end
          MODE_XFORM: restart_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_r <= d2_nxt;
      c2_r <= cen;
      if (v1_r && (mode1_r == MODE_BOX)) begin
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

  pcrt_row u_row_x (
    .clk(clk), .en(adv), .rot_row(rot_row0_r), .d(d2_r), .cen(c2_r.x),
    .shift(shift_x_r), .q(qx), .clip(clip_x)
  );

  pcrt_row u_row_y (
    .clk(clk), .en(adv), .rot_row(rot_row1_r), .d(d2_r), .cen(c2_r.y),
    .shift(shift_y_r), .q(qy), .clip(clip_y)
  );

  pcrt_row u_row_z (
    .clk(clk), .en(adv), .rot_row(rot_row2_r), .d(d2_r), .cen(c2_r.z),
    .shift(shift_z_r), .q(qz), .clip(clip_z)
  );

  // Advance valid through the product and round stages into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r   <= qx;
      qy_r   <= qy;
      qz_r   <= qz;
      clip_r <= clip_x || clip_y || clip_z;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_qx      = qx_r;
  assign out_qy      = qy_r;
  assign out_qz      = qz_r;
  assign out_clipped = clip_r;

endmodule

/* rtl/pcrt_checker.sv */
module pcrt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pcrt_pkg::coord_t   out_qx,
  input pcrt_pkg::coord_t   out_qy,
  input pcrt_pkg::coord_t   out_qz,
  input logic               out_clipped
);
  import pcrt_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_qx) && $stable(out_qy)
      && $stable(out_qz) && $stable(out_clipped))
    else $error("result beat changed while stalled");

  // Input stalls only behind an unclaimed result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // A clipped result has at least one coordinate pinned at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_qx == COORD_MAX || out_qx == COORD_MIN ||
      out_qy == COORD_MAX || out_qy == COORD_MIN ||
      out_qz == COORD_MAX || out_qz == COORD_MIN)
    else $error("clipped flag without a saturated coordinate");

  // Pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind point_cloud_rigid_transform_about_center pcrt_checker u_pcrt_checker (.*);

/* tb/sv/xform_scoreboard_pkg.sv */
package xform_scoreboard_pkg;
  import pcrt_pkg::*;

  localparam int AXES        = 3;

  typedef struct packed {
    coord_t qx;
    coord_t qy;
    coord_t qz;
    logic   clipped;
  } xform_result_t;

  class xform_scoreboard;
    row_t          rot_row [AXES];
    longint        shift   [AXES];
    longint        box_lo  [AXES];
    longint        box_hi  [AXES];
    bit            box_valid;
    bit            restart_due;
    xform_result_t expected_points [$];
    int            errors;

    function new();
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      rot_row[0] = ROW0_RST;
      rot_row[1] = ROW1_RST;
      rot_row[2] = ROW2_RST;
      for (int a = 0; a < AXES; a++) begin
        shift[a]  = 0;
        box_lo[a] = 0;
        box_hi[a] = 0;
      end
      box_valid   = 1'b0;
      restart_due = 1'b1;
      expected_points.delete();
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // Only the low coordinate bits of a shift register count.
    function void write_reg(logic [IDX_W-1:0] idx, row_t data);
      coord_t low;
      low = data[CW-1:0];
      case (idx)
        REG_ROT_ROW0: rot_row[0] = data;
        REG_ROT_ROW1: rot_row[1] = data;
        REG_ROT_ROW2: rot_row[2] = data;
        REG_SHIFT_X:  shift[0] = low;
        REG_SHIFT_Y:  shift[1] = low;
        REG_SHIFT_Z:  shift[2] = low;
        default: ;
      endcase
    endfunction

    function void note_point(mode_t mode, coord_t x, coord_t y, coord_t z);
      longint        p [AXES];
      longint        c [AXES];
      longint        d [AXES];
      coord_t        q [AXES];
      longint        acc;
      longint        sat_hi;
      longint        sat_lo;
      rot_t          e;
      xform_result_t r;
      p[0] = x;
      p[1] = y;
      p[2] = z;
      sat_hi = COORD_MAX;
      sat_lo = COORD_MIN;
      if (mode == MODE_BOX) begin
        for (int a = 0; a < AXES; a++) begin
          if (restart_due) begin
            box_lo[a] = p[a];
            box_hi[a] = p[a];
          end else begin
            if (p[a] < box_lo[a]) box_lo[a] = p[a];
            if (p[a] > box_hi[a]) box_hi[a] = p[a];
          end
        end
        box_valid   = 1'b1;
        restart_due = 1'b0;
        return;
      end
      for (int a = 0; a < AXES; a++) begin
        c[a] = box_valid ? (box_hi[a] + box_lo[a]) >>> 1 : 0;
        d[a] = p[a] - c[a];
      end
      r.clipped = 1'b0;
      for (int a = 0; a < AXES; a++) begin
        acc = 0;
        for (int k = 0; k < AXES; k++) begin
          e = rot_row[a][(AXES - 1 - k) * ROT_W +: ROT_W];
          acc += e * d[k];
        end
        acc = ((acc + ROUND_BIAS) >>> FRAC_W) + shift[a] + c[a];
        if (acc > sat_hi) begin
          acc = sat_hi;
          r.clipped = 1'b1;
        end else if (acc < sat_lo) begin
          acc = sat_lo;
          r.clipped = 1'b1;
        end
        q[a] = coord_t'(acc);
      end
      r.qx = q[0];
      r.qy = q[1];
      r.qz = q[2];
      expected_points.insert(expected_points.size(), r);
      restart_due = 1'b1;
    endfunction

    function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(coord_t qx, coord_t qy, coord_t qz, logic clipped);
      xform_result_t r;
      if (expected_points.size() == 0) begin
        $error("result with nothing expected: qx=%0d qy=%0d qz=%0d clipped=%0b",
               qx, qy, qz, clipped);
        errors++;
        return;
      end
      r = expected_points.pop_front();
      compare("qx", r.qx, qx);
      compare("qy", r.qy, qy);
      compare("qz", r.qz, qz);
      compare("clipped", r.clipped, clipped);
    endfunction
  endclass

endpackage

/* tb/sv/tb_point_cloud_rigid_transform_about_center.sv */
module tb_point_cloud_rigid_transform_about_center;
  timeunit 1ns;
  timeprecision 1ps;

  import pcrt_pkg::*;
  import xform_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no beat on any channel
  localparam int LONG_HOLD       = 250;   // receiver hold-off, in cycles
  localparam int SETTLE          = 10;    // box beats leave no result; let them clear
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int QUIET_PHASES    = 2;     // tail of the run with no idling
  localparam int HOLD_PHASE      = 5;
  localparam int HOLD_FLOOD      = 40;
  localparam int ENTRY_ONE       = 1 << FRAC_W;

  localparam rot_t ENTRY_MAX = {1'b0, {(ROT_W-1){1'b1}}};
  localparam rot_t ENTRY_MIN = {1'b1, {(ROT_W-1){1'b0}}};

  // Index past the last register; the block must ignore writes to it.
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(int'(REG_SHIFT_Z) + 1);

  typedef enum {SET_RANDOM, SET_AXIS, SET_TOP, SET_BOTTOM, SET_ZERO} setting_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  logic   in_mode   = 1'b0;
  coord_t in_px     = '0;
  coord_t in_py     = '0;
  coord_t in_pz     = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_qx;
  coord_t out_qy;
  coord_t out_qz;
  logic   out_clipped;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  row_t   cfg_data  = '0;

  // Idling knobs for the sender and the receiver.
  bit send_gaps   = 1'b1;
  bit recv_stalls = 1'b1;
  bit hold_req    = 1'b0;

  int quiet_cycles = 0;

  xform_scoreboard sb;

  point_cloud_rigid_transform_about_center uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_px      (in_px),
    .in_py      (in_py),
    .in_pz      (in_pz),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_qx     (out_qx),
    .out_qy     (out_qy),
    .out_qz     (out_qz),
    .out_clipped(out_clipped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Value pickers. Half of the coordinates stay within +/-128.0 so that the rotated
  // points mostly land in range; the rest hit the rails or take any pattern.
  // ---------------------------------------------------------------------------
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3, 4: return coord_t'($urandom());
      default: return coord_t'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  function automatic rot_t rand_entry();
    case ($urandom_range(0, 3))
      0:       return rot_t'($urandom());
      default: return rot_t'(int'($urandom_range(0, 2 * ENTRY_ONE)) - ENTRY_ONE);
    endcase
  endfunction

  function automatic coord_t rand_shift();
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return coord_t'($urandom());
      default: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one point beat and hold it until the block takes it. A gap
  // burst may come first. Valid is only raised here, never lowered and raised
  // in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_point(input mode_t m, input coord_t x, input coord_t y,
                            input coord_t z);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_px    <= x;
    in_py    <= y;
    in_pz    <= z;
    do @(posedge clk); while (!in_ready);
    sb.note_point(m, x, y, z);
  endtask

  // Stop offering and wait until every transform result is back, then let
  // trailing box beats clear the pipe before anything touches the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input row_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Write all six registers for one setting. Upper bits of the shift words
  // carry junk that the block must ignore.
  task automatic load_setting(input setting_t s);
    rot_t     e [AXES*AXES];
    coord_t   t [AXES];
    row_t     raw;
    cfg_reg_t rg;
    int       ax;
    for (int i = 0; i < AXES * AXES; i++)
      case (s)
        SET_AXIS:   e[i] = rot_t'((int'($urandom_range(0, 2)) - 1) * ENTRY_ONE);
        SET_TOP:    e[i] = ENTRY_MAX;
        SET_BOTTOM: e[i] = ENTRY_MIN;
        SET_ZERO:   e[i] = '0;
        default:    e[i] = rand_entry();
      endcase
    for (int k = 0; k < AXES; k++)
      case (s)
        SET_TOP:    t[k] = COORD_MAX;
        SET_BOTTOM: t[k] = COORD_MIN;
        SET_ZERO:   t[k] = coord_t'($urandom());
        default:    t[k] = rand_shift();
      endcase
    rg = rg.first();
    do begin
      raw = row_t'({$urandom(), $urandom()});
      ax  = int'(rg) % AXES;
      if (rg <= REG_ROT_ROW2)
        raw = {e[AXES*ax], e[AXES*ax+1], e[AXES*ax+2]};
      else
        raw[CW-1:0] = t[ax];
      write_reg(rg, raw);
      rg = rg.next();
    end while (rg != rg.first());
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_UNUSED, row_t'({$urandom(), $urandom()}));
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed opening: empty box, box restart and widening, center flooring,
  // widest difference, rounding of halves, saturation on both rails.
  // ---------------------------------------------------------------------------
  task automatic run_directed();
    // Nothing boxed yet: center is zero and the identity rotation echoes p.
    send_point(MODE_XFORM, '0, '0, '0);
    send_point(MODE_XFORM, COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(MODE_XFORM, COORD_MIN, COORD_MAX, coord_t'(1));
    // First box beat replaces the box, the next ones widen it.
    send_point(MODE_BOX, COORD_MIN, COORD_MAX, '0);
    send_point(MODE_BOX, COORD_MAX, COORD_MIN, coord_t'(-1));
    send_point(MODE_BOX, coord_t'(5), coord_t'(-5), coord_t'(3));
    // min + max is odd in x and y: the center floors to -1 there, so p - c reaches full width.
    // Back-to-back transforms share the same box.
    send_point(MODE_XFORM, '0, '0, '0);
    send_point(MODE_XFORM, COORD_MAX, COORD_MIN, coord_t'(100));
    send_point(MODE_XFORM, COORD_MIN, COORD_MAX, coord_t'(-100));
    // Restart with one point at the origin for the rounding beats below.
    send_point(MODE_BOX, '0, '0, '0);
    drain();
    write_reg(REG_ROT_ROW0, {rot_t'(1), rot_t'(0), rot_t'(0)});
    write_reg(REG_ROT_ROW1, {ENTRY_MIN, ENTRY_MIN, ENTRY_MIN});
    write_reg(REG_ROT_ROW2, {ENTRY_MAX, ENTRY_MAX, ENTRY_MAX});
    write_reg(REG_SHIFT_X, '0);
    write_reg(REG_SHIFT_Y, row_t'(COORD_MIN));
    write_reg(REG_SHIFT_Z, row_t'(COORD_MAX));
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    // x weighs px by one Q1.14 LSB: +half rounds up to 1, -half up to 0.
    // y and z sit on the rails, so larger points clip both ways.
    send_point(MODE_XFORM, coord_t'(8192), coord_t'(1000), coord_t'(1000));
    send_point(MODE_XFORM, coord_t'(-8192), '0, '0);
    send_point(MODE_XFORM, coord_t'(-8193), coord_t'(-1000), '0);
    send_point(MODE_XFORM, coord_t'(8191), '0, '0);
    send_point(MODE_XFORM, coord_t'(24576), COORD_MIN, COORD_MIN);
  endtask

  // ---------------------------------------------------------------------------
  // Random clouds: mostly a box pass followed by a few transforms, with some
  // noise runs of random modes where transforms reuse a stale box.
  // ---------------------------------------------------------------------------
  task automatic run_clouds(input int budget);
    int sent = 0;
    int n_box;
    int n_xform;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        n_box   = $urandom_range(1, 6);
        n_xform = 0;
        repeat (n_box)
          send_point(mode_t'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord());
      end else begin
        n_box   = $urandom_range(1, 12);
        n_xform = $urandom_range(1, 6);
        repeat (n_box) send_point(MODE_BOX, rand_coord(), rand_coord(), rand_coord());
        repeat (n_xform) send_point(MODE_XFORM, rand_coord(), rand_coord(), rand_coord());
      end
      sent += n_box + n_xform;
    end
  endtask

  // Ask the receiver for a long hold-off and keep offering transforms, so the
  // result register fills and in_ready drops.
  task automatic flood_while_held();
    hold_req = 1'b1;
    send_point(MODE_BOX, rand_coord(), rand_coord(), rand_coord());
    send_point(MODE_BOX, rand_coord(), rand_coord(), rand_coord());
    repeat (HOLD_FLOOD) send_point(MODE_XFORM, rand_coord(), rand_coord(), rand_coord());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    setting_t s;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      // Pause the sender until every result is home, then reprogram.
      drain();
      case (ph)
        0:       s = SET_AXIS;
        1:       s = SET_TOP;
        2:       s = SET_BOTTOM;
        3:       s = SET_ZERO;
        default: s = ($urandom_range(0, 3) == 0) ? SET_AXIS : SET_RANDOM;
      endcase
      load_setting(s);
      if (ph == PHASES - QUIET_PHASES) begin
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
      end
      if (ph == HOLD_PHASE)
        flood_while_held();
      run_clouds(ITEMS_PER_PHASE);
    end
    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready by default, random stall bursts, and one long hold-off
  // counted here when the main sequence asks for it.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check each result beat against the oldest expectation. Values read here
  // are the ones present at the edge, since all drivers use nonblocking writes.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_qx, out_qy, out_qz, out_clipped);
  end

  // Drop the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
